[rtl/core/nmm_pkg.sv]
// Shared constants, register codes and types for the noise gate monitor mixer.
package nmm_pkg;

    // Default field widths
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_GAIN_FRAC_BITS = 24;

    // Shared multiplier: signed operands, wide enough for every product used
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Leaky energy tracker coefficients (over 2^16)
    localparam logic [15:0] ENERGY_KEEP  = 16'd65470;
    localparam logic [15:0] ENERGY_TAKE  = 16'd66;
    localparam int          ENERGY_SHIFT = 16;
    localparam logic [31:0] ENERGY_RST   = 32'd4295;
    localparam logic [31:0] ENERGY_MAX   = 32'hFFFF_FFFF;

    // Smoothing steps are Q1.24, unity is 2^24
    localparam int          STEP_W     = 25;
    localparam int          STEP_SHIFT = 24;
    localparam logic [24:0] STEP_ONE   = 25'h100_0000;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_EN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAKE_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATK_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_STEP = 3'd5;

    // Register reset values
    localparam logic [31:0]       RST_OPEN_THR = 32'd85899;
    localparam logic [STEP_W-1:0] RST_ATK_STEP = 25'd8389;
    localparam logic [STEP_W-1:0] RST_REL_STEP = 25'd1678;

    typedef struct packed {
        logic              gate_en;
        logic              mon_en;
        logic              bake_en;
        logic [31:0]       open_thr;
        logic [STEP_W-1:0] atk_step;
        logic [STEP_W-1:0] rel_step;
    } t_cfg;

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

endpackage

[rtl/core/nmm_in_if.sv]
// Input channel: one stereo mic frame plus the timeline mix frame.
interface nmm_in_if #(
    parameter int SAMPLE_BITS = nmm_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mic_left;
    logic signed [SAMPLE_BITS-1:0] mic_right;
    logic signed [SAMPLE_BITS-1:0] mix_left;
    logic signed [SAMPLE_BITS-1:0] mix_right;

    modport source (
        output valid, mic_left, mic_right, mix_left, mix_right,
        input  ready
    );
    modport sink (
        input  valid, mic_left, mic_right, mix_left, mix_right,
        output ready
    );
endinterface

[rtl/core/nmm_out_if.sv]
// Output channel: monitored mix, recorded frame, gate status and gain.
interface nmm_out_if #(
    parameter int SAMPLE_BITS    = nmm_pkg::DEF_SAMPLE_BITS,
    parameter int GAIN_FRAC_BITS = nmm_pkg::DEF_GAIN_FRAC_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic signed [SAMPLE_BITS-1:0] rec_left;
    logic signed [SAMPLE_BITS-1:0] rec_right;
    logic                          gate_is_open;
    logic [GAIN_FRAC_BITS:0]       gain_now;

    modport source (
        output valid, out_left, out_right, rec_left, rec_right, gate_is_open, gain_now,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_right, rec_left, rec_right, gate_is_open, gain_now,
        output ready
    );
endinterface

[rtl/core/nmm_mul.sv]
// Shared signed multiplier with registered product.
module nmm_mul (
    input  logic                                i_clk,
    input  nmm_pkg::t_mul_req                   i_req,
    output logic signed [nmm_pkg::PROD_W-1:0]   o_prod
);
    import nmm_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // product loads only when a step issues a request, else it holds
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= $signed(i_req.a) * $signed(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

[rtl/core/nmm_seq.sv]
// Sequencer and datapath: energy tracking, gain smoothing, gating and mixing.
module nmm_seq #(
    parameter int SAMPLE_BITS    = nmm_pkg::DEF_SAMPLE_BITS,
    parameter int GAIN_FRAC_BITS = nmm_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nmm_pkg::t_cfg                       i_cfg,
    nmm_in_if.sink                              i_in,
    nmm_out_if.source                           o_out,
    output nmm_pkg::t_mul_req                   o_mul_req,
    input  logic signed [nmm_pkg::PROD_W-1:0]   i_prod
);
    import nmm_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int GFB = GAIN_FRAC_BITS;
    localparam int SQ_SHIFT = 2 * SB - 32;
    localparam logic [GFB:0] GAIN_ONE = {1'b1, {GFB{1'b0}}};

    // Sequencer state codes
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_E1   = 4'd2;
    localparam logic [3:0] ST_E2   = 4'd3;
    localparam logic [3:0] ST_CMP  = 4'd4;
    localparam logic [3:0] ST_GAIN = 4'd5;
    localparam logic [3:0] ST_GUPD = 4'd6;
    localparam logic [3:0] ST_GL   = 4'd7;
    localparam logic [3:0] ST_GR   = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    logic [3:0]           r_state, n_state;
    logic signed [SB-1:0] r_mic_l, r_mic_r, r_mix_l, r_mix_r;
    logic                 r_sq_big;
    logic [31:0]          r_sq;
    logic [47:0]          r_acc;
    logic [31:0]          r_energy;
    logic                 r_open;
    logic                 r_rise;
    logic [GFB:0]         r_gain;
    logic signed [SB-1:0] r_gl;

    logic                 r_out_valid;
    logic signed [SB-1:0] r_o_left, r_o_right, r_rec_left, r_rec_right;
    logic                 r_o_open;
    logic [GFB:0]         r_o_gain;

    logic                 accept;
    logic                 out_free;
    logic [PROD_W-1:0]    prod_u;
    logic signed [33:0]   sum34;
    logic [33:0]          mag34;
    logic [PROD_W-1:0]    sq_sh;
    logic [31:0]          sq_val;
    logic [49:0]          e_sum;
    logic [33:0]          e_sh;
    logic [31:0]          e_val;
    logic [STEP_W-1:0]    atk_c, rel_c;
    logic                 rise;
    logic [GFB:0]         diff;
    logic [GFB:0]         delta;
    logic [GFB:0]         gg;
    logic signed [PROD_W-1:0] gated_sh;
    logic signed [SB-1:0] gated;

    // saturate a sum one bit wider than a sample back into sample range
    function automatic logic signed [SB-1:0] f_clamp(input logic signed [SB:0] s);
        logic signed [SB-1:0] res;
        if (s[SB] != s[SB-1]) begin
            res = s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end else begin
            res = s[SB-1:0];
        end
        return res;
    endfunction

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;
    assign prod_u      = i_prod;

    // mono sum magnitude; above 32 bits the square saturates
    assign sum34 = 34'(r_mic_l) + 34'(r_mic_r);
    assign mag34 = sum34[33] ? 34'(-sum34) : 34'(sum34);

    // Q0.32 square of the mono average
    assign sq_sh  = prod_u >> SQ_SHIFT;
    assign sq_val = (r_sq_big || (sq_sh[PROD_W-1:32] != '0)) ? ENERGY_MAX : sq_sh[31:0];

    // energy update: (keep*E + take*sq) >> 16, saturated
    assign e_sum = {2'b00, r_acc} + prod_u[49:0];
    assign e_sh  = e_sum[49:ENERGY_SHIFT];
    assign e_val = (e_sh[33:32] != 2'b00) ? ENERGY_MAX : e_sh[31:0];

    // gain smoothing: steps above unity act as unity
    assign atk_c = (i_cfg.atk_step > STEP_ONE) ? STEP_ONE : i_cfg.atk_step;
    assign rel_c = (i_cfg.rel_step > STEP_ONE) ? STEP_ONE : i_cfg.rel_step;
    assign rise  = r_open && (r_gain < GAIN_ONE);
    assign diff  = rise ? GAIN_ONE - r_gain : (r_open ? '0 : r_gain);
    assign delta = prod_u[STEP_SHIFT +: (GFB + 1)];

    // gated sample, floor toward minus infinity
    assign gg       = i_cfg.gate_en ? r_gain : GAIN_ONE;
    assign gated_sh = i_prod >>> GFB;
    assign gated    = gated_sh[SB-1:0];

    // multiplier operand select
    always_comb begin
        o_mul_req = '0;
        unique case (r_state)
            ST_SQ: begin
                o_mul_req.en = 1'b1;
                o_mul_req.a  = {1'b0, mag34[31:0]};
                o_mul_req.b  = {1'b0, mag34[31:0]};
            end
            ST_E1: begin
                o_mul_req.en = 1'b1;
                o_mul_req.a  = MUL_W'(ENERGY_KEEP);
                o_mul_req.b  = {1'b0, r_energy};
            end
            ST_E2: begin
                o_mul_req.en = 1'b1;
                o_mul_req.a  = MUL_W'(ENERGY_TAKE);
                o_mul_req.b  = {1'b0, r_sq};
            end
            ST_GAIN: begin
                o_mul_req.en = 1'b1;
                o_mul_req.a  = MUL_W'(rise ? atk_c : rel_c);
                o_mul_req.b  = MUL_W'(diff);
            end
            ST_GL: begin
                o_mul_req.en = 1'b1;
                o_mul_req.a  = MUL_W'(r_mic_l);
                o_mul_req.b  = MUL_W'(gg);
            end
            ST_GR: begin
                o_mul_req.en = 1'b1;
                o_mul_req.a  = MUL_W'(r_mic_r);
                o_mul_req.b  = MUL_W'(gg);
            end
            default: begin
                o_mul_req = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_SQ;
            ST_SQ:   n_state = ST_E1;
            ST_E1:   n_state = ST_E2;
            ST_E2:   n_state = ST_CMP;
            ST_CMP:  n_state = ST_GAIN;
            ST_GAIN: n_state = ST_GUPD;
            ST_GUPD: n_state = ST_GL;
            ST_GL:   n_state = ST_GR;
            ST_GR:   n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_energy    <= ENERGY_RST;
            r_gain      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CMP) begin
                r_energy <= e_val;
            end
            if (r_state == ST_GUPD) begin
                r_gain <= r_rise ? r_gain + delta : r_gain - delta;
            end
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and intermediate values
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mic_l <= i_in.mic_left;
            r_mic_r <= i_in.mic_right;
            r_mix_l <= i_in.mix_left;
            r_mix_r <= i_in.mix_right;
        end
        if (r_state == ST_SQ) begin
            r_sq_big <= (mag34[33:32] != 2'b00);
        end
        if (r_state == ST_E1) begin
            r_sq <= sq_val;
        end
        if (r_state == ST_E2) begin
            r_acc <= prod_u[47:0];
        end
        if (r_state == ST_CMP) begin
            r_open <= (e_val > i_cfg.open_thr);
        end
        if (r_state == ST_GAIN) begin
            r_rise <= rise;
        end
        if (r_state == ST_GR) begin
            r_gl <= gated;
        end
        if (r_state == ST_FIN && out_free) begin
            r_o_left    <= i_cfg.mon_en ? f_clamp((SB+1)'(r_mix_l) + (SB+1)'(r_gl)) : r_mix_l;
            r_o_right   <= i_cfg.mon_en ? f_clamp((SB+1)'(r_mix_r) + (SB+1)'(gated)) : r_mix_r;
            r_rec_left  <= i_cfg.bake_en ? r_gl : r_mic_l;
            r_rec_right <= i_cfg.bake_en ? gated : r_mic_r;
            r_o_open    <= r_open;
            r_o_gain    <= r_gain;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_left     = r_o_left;
    assign o_out.out_right    = r_o_right;
    assign o_out.rec_left     = r_rec_left;
    assign o_out.rec_right    = r_rec_right;
    assign o_out.gate_is_open = r_o_open;
    assign o_out.gain_now     = r_o_gain;

`ifndef SYNTHESIS
    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= GAIN_ONE)
        else $error("gate gain above unity");

    a_rise_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GUPD && r_rise) |=> r_gain >= $past(r_gain))
        else $error("gain fell during attack");

    a_fall_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GUPD && !r_rise) |=> r_gain <= $past(r_gain))
        else $error("gain rose during release");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished item not loaded into output register");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (!i_in.ready && r_state == ST_SQ))
        else $error("accepted item did not start the sequence");
`endif

endmodule

[rtl/core/noise_gate_monitor_mixer.sv]
// Top level: configuration registers, sequencer and shared multiplier.
// One item at a time; the single shared multiplier runs six
// products per item (square, two energy terms, gain step, two gated samples).
// Ready stays low from acceptance until the result enters the output register.
// Synchronous active-low reset restores register defaults, energy and gain.
module noise_gate_monitor_mixer #(
    parameter int SAMPLE_BITS    = nmm_pkg::DEF_SAMPLE_BITS,
    parameter int GAIN_FRAC_BITS = nmm_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nmm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [nmm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    nmm_in_if.sink                              i_in,
    nmm_out_if.source                           o_out
);
    import nmm_pkg::*;

    t_cfg                     r_cfg;
    t_mul_req                 mul_req;
    logic signed [PROD_W-1:0] mul_prod;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_en  <= 1'b1;
            r_cfg.mon_en   <= 1'b0;
            r_cfg.bake_en  <= 1'b0;
            r_cfg.open_thr <= RST_OPEN_THR;
            r_cfg.atk_step <= RST_ATK_STEP;
            r_cfg.rel_step <= RST_REL_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GATE_EN:  r_cfg.gate_en  <= i_cfg_data[0];
                CFG_MON_EN:   r_cfg.mon_en   <= i_cfg_data[0];
                CFG_BAKE_EN:  r_cfg.bake_en  <= i_cfg_data[0];
                CFG_OPEN_THR: r_cfg.open_thr <= i_cfg_data[31:0];
                CFG_ATK_STEP: r_cfg.atk_step <= i_cfg_data[STEP_W-1:0];
                CFG_REL_STEP: r_cfg.rel_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    nmm_seq #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_mul_req (mul_req),
        .i_prod    (mul_prod)
    );

    nmm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

endmodule

[test/tb_top.sv]
// Testbench for the noise gate monitor mixer: directed table, random phases, self-checking.
`timescale 1ns / 100ps

module tb_top;
    import nmm_pkg::*;

    localparam int SB = 24;
    localparam int GB = 24;

    localparam longint UNITY    = 64'sd16777216;
    localparam longint NRG_MAX  = 64'sd4294967295;
    localparam longint NRG_KEEP = 64'sd65470;
    localparam longint NRG_TAKE = 64'sd66;

    localparam logic signed [SB-1:0] SMP_MAX = 24'sh7F_FFFF;
    localparam logic signed [SB-1:0] SMP_MIN = 24'sh80_0000;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_REPORTS     = 50;

    typedef struct packed {
        logic signed [SB-1:0] mic_l;
        logic signed [SB-1:0] mic_r;
        logic signed [SB-1:0] mix_l;
        logic signed [SB-1:0] mix_r;
    } t_frame;

    typedef struct packed {
        logic signed [SB-1:0] out_l;
        logic signed [SB-1:0] out_r;
        logic signed [SB-1:0] rec_l;
        logic signed [SB-1:0] rec_r;
        logic                 is_open;
        logic [GB:0]          gain;
    } t_mix_out;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_FRAME,
        ROW_KNOWN
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_frame                frm;
        t_mix_out              want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    nmm_in_if  #(.SAMPLE_BITS(SB))                     in_if ();
    nmm_out_if #(.SAMPLE_BITS(SB), .GAIN_FRAC_BITS(GB)) out_if ();

    noise_gate_monitor_mixer #(
        .SAMPLE_BITS    (SB),
        .GAIN_FRAC_BITS (GB)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    // Shadow of the block: registers, energy tracker and gate gain
    t_cfg        shadow_cfg;
    logic [31:0] nrg_level;
    logic [GB:0] gate_gain;

    t_mix_out gated_mix_q [$];
    int       mismatch_cnt  = 0;
    int       src_idle_pct  = 0;
    int       snk_stall_pct = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [SB-1:0] clamp_smp(input longint v);
        if (v > 64'sd8388607)
            return SMP_MAX;
        if (v < -64'sd8388608)
            return SMP_MIN;
        return v[SB-1:0];
    endfunction

    // Advance energy and gain by one frame, then form the mix and record outputs
    function automatic t_mix_out gated_mix_of(input t_frame f);
        longint   mic_sum, mag, sq, nxt, stp, g, gg, gl, gr;
        logic     is_open;
        t_mix_out r;
        mic_sum = longint'($signed(f.mic_l)) + longint'($signed(f.mic_r));
        mag     = (mic_sum < 0) ? -mic_sum : mic_sum;
        sq      = (mag * mag) >> 16;
        if (sq > NRG_MAX)
            sq = NRG_MAX;
        nxt = (NRG_KEEP * longint'(nrg_level) + NRG_TAKE * sq) >> 16;
        if (nxt > NRG_MAX)
            nxt = NRG_MAX;
        nrg_level = nxt[31:0];
        is_open   = (nrg_level > shadow_cfg.open_thr);

        // attack toward unity, release toward zero; steps above unity act as unity
        g = longint'(gate_gain);
        if (is_open && g < UNITY) begin
            stp = (longint'(shadow_cfg.atk_step) > UNITY) ? UNITY : longint'(shadow_cfg.atk_step);
            g   = g + ((stp * (UNITY - g)) >> 24);
        end else if (!is_open && g > 0) begin
            stp = (longint'(shadow_cfg.rel_step) > UNITY) ? UNITY : longint'(shadow_cfg.rel_step);
            g   = g - ((stp * g) >> 24);
        end
        gate_gain = g[GB:0];

        gg = shadow_cfg.gate_en ? g : UNITY;
        gl = (longint'($signed(f.mic_l)) * gg) >>> GB;
        gr = (longint'($signed(f.mic_r)) * gg) >>> GB;

        r.out_l   = shadow_cfg.mon_en ? clamp_smp(longint'($signed(f.mix_l)) + gl) : f.mix_l;
        r.out_r   = shadow_cfg.mon_en ? clamp_smp(longint'($signed(f.mix_r)) + gr) : f.mix_r;
        r.rec_l   = shadow_cfg.bake_en ? gl[SB-1:0] : f.mic_l;
        r.rec_r   = shadow_cfg.bake_en ? gr[SB-1:0] : f.mic_r;
        r.is_open = is_open;
        r.gain    = gate_gain;
        return r;
    endfunction

    function automatic void field_check(input string name, input longint want, input longint got);
        if (want != got) begin
            if (mismatch_cnt < MAX_REPORTS)
                $error("%s expected %0d got %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // Table row builders
    function automatic t_row wr(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        t_row r;
        r      = '{kind: ROW_WRITE, idx: idx, data: data, frm: '0, want: '0};
        return r;
    endfunction

    function automatic t_row fr(input logic signed [SB-1:0] ml, input logic signed [SB-1:0] mr,
                                input logic signed [SB-1:0] xl, input logic signed [SB-1:0] xr);
        t_row r;
        r     = '{kind: ROW_FRAME, idx: '0, data: '0, frm: '0, want: '0};
        r.frm = '{mic_l: ml, mic_r: mr, mix_l: xl, mix_r: xr};
        return r;
    endfunction

    // Known result with the gate closed and the gain still at zero
    function automatic t_row kn(input logic signed [SB-1:0] ml, input logic signed [SB-1:0] mr,
                                input logic signed [SB-1:0] xl, input logic signed [SB-1:0] xr,
                                input logic signed [SB-1:0] ol, input logic signed [SB-1:0] orr,
                                input logic signed [SB-1:0] rl, input logic signed [SB-1:0] rr);
        t_row r;
        r      = fr(ml, mr, xl, xr);
        r.kind = ROW_KNOWN;
        r.want = '{out_l: ol, out_r: orr, rec_l: rl, rec_r: rr, is_open: 1'b0, gain: '0};
        return r;
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(7))
            0:       return '0;
            1:       return STEP_ONE;
            2:       return STEP_W'($urandom_range(25'h1FF_FFFF, 25'h100_0001));
            3:       return STEP_W'($urandom_range(4096));
            default: return STEP_W'($urandom_range(25'h100_0000));
        endcase
    endfunction

    function automatic logic signed [SB-1:0] quiet_smp(input int bits);
        int v;
        v = int'($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
        return v[SB-1:0];
    endfunction

    function automatic logic signed [SB-1:0] rand_mix();
        case ($urandom_range(15))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            default: return SB'($urandom);
        endcase
    endfunction

    // Wait until every pending result has come back
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (gated_mix_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Register write; the first of a run of writes waits for the block to go idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        if (cfg_we !== 1'b1)
            wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_GATE_EN:  shadow_cfg.gate_en  = data[0];
            CFG_MON_EN:   shadow_cfg.mon_en   = data[0];
            CFG_BAKE_EN:  shadow_cfg.bake_en  = data[0];
            CFG_OPEN_THR: shadow_cfg.open_thr = data;
            CFG_ATK_STEP: shadow_cfg.atk_step = data[STEP_W-1:0];
            CFG_REL_STEP: shadow_cfg.rel_step = data[STEP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Offer one frame, with random idle gaps ahead of it
    task automatic send_frame(input t_frame f, input bit typed, input t_mix_out known);
        t_mix_out res;
        if (cfg_we === 1'b1)
            cfg_we <= 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.mic_left  <= f.mic_l;
        in_if.mic_right <= f.mic_r;
        in_if.mix_left  <= f.mix_l;
        in_if.mix_right <= f.mix_r;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        res = gated_mix_of(f);
        gated_mix_q.insert(gated_mix_q.size(), typed ? known : res);
        @(negedge i_clk);
    endtask

    // Receiver backpressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Result checker
    initial begin
        t_mix_out want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (gated_mix_q.size() == 0) begin
                    $error("result arrived with no frame pending");
                    mismatch_cnt++;
                end else begin
                    want = gated_mix_q.pop_front();
                    field_check("out_left", want.out_l, $signed(out_if.out_left));
                    field_check("out_right", want.out_r, $signed(out_if.out_right));
                    field_check("rec_left", want.rec_l, $signed(out_if.rec_left));
                    field_check("rec_right", want.rec_r, $signed(out_if.rec_right));
                    field_check("gate_is_open", want.is_open, out_if.gate_is_open);
                    field_check("gain_now", want.gain, out_if.gain_now);
                end
            end
        end
    end

    // Watchdog: ends the run after too long without any handshake
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) || cfg_we === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_row        dir_tab [$];
        t_frame      f;
        logic [31:0] thr;
        int          n, burst_len, amp_bits;
        bit          loud;

        in_if.valid     <= 1'b0;
        in_if.mic_left  <= '0;
        in_if.mic_right <= '0;
        in_if.mix_left  <= '0;
        in_if.mix_right <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= '0;
        cfg_data        <= '0;
        i_rst_n         <= 1'b0;

        shadow_cfg = '{gate_en: 1'b1, mon_en: 1'b0, bake_en: 1'b0, open_thr: 32'd85899,
                       atk_step: 25'd8389, rel_step: 25'd1678};
        nrg_level  = 32'd4295;
        gate_gain  = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_tab = '{
            // reset state: gate closed, gain zero, mix passed through, mic recorded raw
            kn(0, 0, 0, 0, 0, 0, 0, 0),
            kn(0, 0, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, 0, 0),
            kn(SMP_MAX, SMP_MIN, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MAX, SMP_MIN),
            kn(SMP_MIN, SMP_MAX, -1, 1, -1, 1, SMP_MIN, SMP_MAX),
            // loud frames open the gate; full negative sum saturates the square
            fr(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MIN),
            fr(SMP_MIN, SMP_MIN, 0, 0),
            // monitoring and bake on, clamping at both rails
            wr(CFG_MON_EN, 1),
            wr(CFG_BAKE_EN, 1),
            fr(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX),
            fr(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN),
            fr(-1, -1, 0, 0),
            // attack step above unity jumps the gain straight to unity
            wr(CFG_ATK_STEP, 32'h01FF_FFFF),
            fr(24'sd123456, -24'sd654321, 24'sd1000, -24'sd1000),
            fr(SMP_MIN, SMP_MAX, 0, 0),
            // gate never opens, full release drops the gain to zero
            wr(CFG_OPEN_THR, 32'hFFFF_FFFF),
            wr(CFG_REL_STEP, STEP_ONE),
            fr(SMP_MAX, SMP_MAX, 1, 1),
            // gate disabled: gated mic equals raw mic
            wr(CFG_GATE_EN, 0),
            fr(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN),
            // threshold zero with zero attack: open, gain frozen
            wr(CFG_OPEN_THR, 0),
            wr(CFG_ATK_STEP, 0),
            fr(5, -7, 0, 0),
            wr(CFG_GATE_EN, 1),
            wr(CFG_ATK_STEP, STEP_ONE),
            fr(1, 1, -3, 3),
            fr(-24'sd4096, 24'sd4095, SMP_MAX, SMP_MIN),
            wr(CFG_REL_STEP, 0),
            wr(CFG_MON_EN, 0),
            wr(CFG_BAKE_EN, 0),
            fr(SMP_MIN, SMP_MAX, 24'sd77, -24'sd77)
        };

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_WRITE)
                write_reg(dir_tab[r].idx, dir_tab[r].data);
            else
                send_frame(dir_tab[r].frm, dir_tab[r].kind == ROW_KNOWN, dir_tab[r].want);
        end

        // Random phases: new settings and idle pattern each phase
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 58; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 58; end
                default: begin src_idle_pct = 11; snk_stall_pct = 11; end
            endcase

            write_reg(CFG_GATE_EN, 32'($urandom_range(1)));
            write_reg(CFG_MON_EN, 32'($urandom_range(1)));
            write_reg(CFG_BAKE_EN, 32'($urandom_range(1)));
            // threshold in half the phases just around the tracked energy so the gate toggles
            case ($urandom_range(5))
                0:       thr = '0;
                1:       thr = '1;
                2:       thr = $urandom;
                default: thr = nrg_level - (nrg_level >> 4) + $urandom_range(nrg_level >> 3);
            endcase
            write_reg(CFG_OPEN_THR, thr);
            write_reg(CFG_ATK_STEP, 32'(pick_step()));
            write_reg(CFG_REL_STEP, 32'(pick_step()));

            // Bursts of loud or quiet frames, chosen at random per burst
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                burst_len = $urandom_range(40, 1);
                loud      = ($urandom_range(1) == 1);
                amp_bits  = $urandom_range(18, 1);
                for (int k = 0; k < burst_len && n < ITEMS_PER_PHASE; k++) begin
                    f.mic_l = loud ? SB'($urandom) : quiet_smp(amp_bits);
                    f.mic_r = loud ? SB'($urandom) : quiet_smp(amp_bits);
                    f.mix_l = rand_mix();
                    f.mix_r = rand_mix();
                    send_frame(f, 1'b0, '0);
                    n++;
                end
            end
        end

        // Drain and report
        if (cfg_we === 1'b1)
            cfg_we <= 1'b0;
        in_if.valid <= 1'b0;
        while (gated_mix_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
rtl/core/nmm_pkg.sv
rtl/core/nmm_in_if.sv
rtl/core/nmm_out_if.sv
rtl/core/nmm_mul.sv
rtl/core/nmm_seq.sv
rtl/core/noise_gate_monitor_mixer.sv
test/tb_top.sv
